/* hw/rtl/lru_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CFG_W     = 5;
    localparam int FAULT_W   = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(FRAMES);

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed
    {
        logic load_page;
        logic commit;
    } dp_cmd_t;

endpackage

/* hw/rtl/lru_regs.sv */
// APB-style configuration register file holding frames_in_use.
// Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_regs
    import lru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CFG_W-1:0]  frames_in_use
);

    logic [CFG_W-1:0] frames_in_use_reg;
    logic [CFG_W-1:0] frames_in_use_next;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE);
    assign pready = 1'b1;

    always_comb
    begin
        frames_in_use_next = frames_in_use_reg;
        if (wr_en)
        begin
            frames_in_use_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RST;
        end
        else
        begin
            frames_in_use_reg <= frames_in_use_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAMES_IN_USE)
        begin
            prdata = APB_DW'(frames_in_use_reg);
        end
    end

    assign frames_in_use = frames_in_use_reg;

endmodule

/* hw/rtl/lru_ctrl.sv */
// Controller: sequences one reference through lookup and commit, and owns
// the output valid flag. Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_ctrl
    import lru_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register can take a new result once the old one is gone.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_page = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_page = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/lru_dpath.sv */
// Datapath: frame table, pairwise age matrix, lookup and victim selection,
// fault counter and result register. Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_dpath
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic [CFG_W-1:0]     frames_in_use,
    input  logic [PAGE_BITS-1:0] page,
    output logic                 hit,
    output logic [3:0]           frame_index,
    output logic                 evicted_valid,
    output logic [15:0]          evicted_page,
    output logic [FAULT_W-1:0]   fault_count
);

    logic [PAGE_BITS-1:0] page_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    valid_next;
    logic [PAGE_BITS-1:0] page_tab_reg [FRAMES];
    // older_reg[i][j] is set when frame i was last used before frame j.
    logic [FRAMES-1:0]    older_reg [FRAMES];
    logic [FAULT_W-1:0]   fault_reg;
    logic [FAULT_W-1:0]   fault_next;

    logic                 hit_out_reg;
    logic [FIDX_W-1:0]    idx_out_reg;
    logic                 ev_valid_out_reg;
    logic [PAGE_BITS-1:0] ev_page_out_reg;

    logic [CFG_W-1:0]     n_eff;
    logic [FRAMES-1:0]    active;
    logic [FRAMES-1:0]    match;
    logic [FRAMES-1:0]    empty;
    logic [FRAMES-1:0]    victim_ok;
    logic                 hit_any;
    logic                 empty_any;
    logic [FIDX_W-1:0]    hit_idx;
    logic [FIDX_W-1:0]    empty_idx;
    logic [FIDX_W-1:0]    vic_idx;
    logic [FIDX_W-1:0]    slot;
    logic                 evict;

    // A count of zero acts as one; anything above the frame count saturates.
    always_comb
    begin
        if (frames_in_use == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (frames_in_use > CFG_W'(FRAMES))
        begin
            n_eff = CFG_W'(FRAMES);
        end
        else
        begin
            n_eff = frames_in_use;
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            active[i] = (CFG_W'(i) < n_eff);
            match[i]  = active[i] && valid_reg[i] && (page_tab_reg[i] == page_reg);
            empty[i]  = active[i] && !valid_reg[i];
        end
    end

    // With unique use stamps exactly one active frame is older than all others.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            victim_ok[i] = active[i];
            for (int j = 0; j < FRAMES; j++)
            begin
                if ((j != i) && active[j] && !older_reg[i][j])
                begin
                    victim_ok[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        vic_idx   = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = FIDX_W'(i);
            end
            if (empty[i])
            begin
                empty_idx = FIDX_W'(i);
            end
            if (victim_ok[i])
            begin
                vic_idx = FIDX_W'(i);
            end
        end
    end

    assign hit_any   = |match;
    assign empty_any = |empty;
    assign evict     = !hit_any && !empty_any;

    always_comb
    begin
        if (hit_any)
        begin
            slot = hit_idx;
        end
        else if (empty_any)
        begin
            slot = empty_idx;
        end
        else
        begin
            slot = vic_idx;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        fault_next = fault_reg;
        if (cmd.commit && !hit_any)
        begin
            valid_next[slot] = 1'b1;
            if (fault_reg != '1)
            begin
                fault_next = fault_reg + FAULT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fault_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_page)
        begin
            page_reg <= page;
        end
        if (cmd.commit)
        begin
            if (!hit_any)
            begin
                page_tab_reg[slot] <= page_reg;
            end
            // Stamp the used frame as the newest one.
            for (int j = 0; j < FRAMES; j++)
            begin
                older_reg[slot][j] <= 1'b0;
                if (FIDX_W'(j) != slot)
                begin
                    older_reg[j][slot] <= 1'b1;
                end
            end
            hit_out_reg      <= hit_any;
            idx_out_reg      <= slot;
            ev_valid_out_reg <= evict;
            ev_page_out_reg  <= evict ? page_tab_reg[slot] : '0;
        end
    end

    assign hit           = hit_out_reg;
    assign frame_index   = 4'(idx_out_reg);
    assign evicted_valid = ev_valid_out_reg;
    assign evicted_page  = 16'(ev_page_out_reg);
    assign fault_count   = fault_reg;

`ifndef SYNTHESIS
    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && evict) |-> $onehot(victim_ok))
        else $error("eviction without a single oldest frame");

    a_fill_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_any) |=>
            (valid_reg[$past(slot)] && (page_tab_reg[$past(slot)] == $past(page_reg))))
        else $error("missed page not installed in its frame");

    a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_any && (fault_reg != '1)) |=>
            (fault_reg == FAULT_W'($past(fault_reg) + FAULT_W'(1))))
        else $error("fault counter did not advance on a miss");
`endif

endmodule

/* hw/rtl/lru_page_replacement.sv */
// LRU page replacement, top level: one page reference per input transfer.
// Flow: the input transfer loads the page register and enters the lookup
// state, where the lookup and the commit into the frame table and result
// register happen together; a held result stalls commit. No new reference
// is accepted until the current one has committed.
// Reset (rst_n, async, active low) empties all frames, clears the fault
// count and sets frames_in_use to 16; no clearing pass is needed.
`timescale 1ns / 1ps

module lru_page_replacement
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_BITS-1:0] page,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [3:0]           frame_index,
    output logic                 evicted_valid,
    output logic [15:0]          evicted_page,
    output logic [FAULT_W-1:0]   fault_count
);

    logic [CFG_W-1:0] frames_in_use;
    dp_cmd_t          cmd;

    lru_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .frames_in_use (frames_in_use)
    );

    lru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lru_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .frames_in_use (frames_in_use),
        .page          (page),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

endmodule
